// ----- rtl/battery_discharge_statistics_core_macros.svh -----
// Assertion helpers used by the core module to check this block.
`ifndef BATTERY_DISCHARGE_STATISTICS_CORE_MACROS_SVH
`define BATTERY_DISCHARGE_STATISTICS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bds_pkg.sv -----
package bds_pkg;

   // Field widths.
   localparam int VOLT_W   = 13;
   localparam int PCT_W    = 7;
   localparam int TIME_W   = 40;
   localparam int CNT_W    = 32;
   localparam int NORM_W   = 42;
   localparam int SCALE_W  = 7;
   localparam int PROD_W   = TIME_W + SCALE_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W   = $clog2(DIV_STEPS);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = VOLT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VALID_LOW  = 3'd0,
      CSR_VALID_HIGH = 3'd1,
      CSR_START_PCT  = 3'd2,
      CSR_END_PCT    = 3'd3,
      CSR_MIN_USED   = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [VOLT_W-1:0] VALID_LOW_RESET  = 13'd2500;
   localparam logic [VOLT_W-1:0] VALID_HIGH_RESET = 13'd4500;
   localparam logic [PCT_W-1:0]  START_PCT_RESET  = 7'd95;
   localparam logic [PCT_W-1:0]  END_PCT_RESET    = 7'd20;
   localparam logic [PCT_W-1:0]  MIN_USED_RESET   = 7'd60;

   // Arithmetic constants.
   localparam logic [PCT_W-1:0]   FULL_PERCENT    = 7'd100;
   localparam logic [CNT_W-1:0]   TENTHS_PER_PCT  = 32'd10;
   localparam logic [SCALE_W-1:0] NORM_SCALE      = 7'd100;
   localparam logic [VOLT_W-1:0]  VOLT_MIN_RESET  = '1;

   typedef struct packed {
      logic [VOLT_W-1:0] valid_low_mv;
      logic [VOLT_W-1:0] valid_high_mv;
      logic [PCT_W-1:0]  start_percent;
      logic [PCT_W-1:0]  end_percent;
      logic [PCT_W-1:0]  min_consumed;
   } cfg_type;

   typedef struct packed {
      logic [VOLT_W-1:0] voltage_mv;
      logic [PCT_W-1:0]  charge_percent;
      logic              is_charging;
      logic              is_full;
      logic [TIME_W-1:0] runtime_ms;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0]  charge_sessions;
      logic [CNT_W-1:0]  charged_tenths;
      logic [CNT_W-1:0]  full_events;
      logic [CNT_W-1:0]  sample_count;
      logic [NORM_W-1:0] latest_norm_ms;
      logic [NORM_W-1:0] reference_norm_ms;
      logic [VOLT_W-1:0] min_mv;
      logic [VOLT_W-1:0] max_mv;
      logic              save_request;
      logic              tracking_active;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
      logic mul;
      logic div_step;
      logic finish;
      logic load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage

// ----- rtl/bds_if.sv -----
// Input channel: one battery sample per item.
interface bds_req_if;
   import bds_pkg::*;

   logic              valid;
   logic              ready;
   logic [VOLT_W-1:0] voltage_mv;
   logic [PCT_W-1:0]  charge_percent;
   logic              is_charging;
   logic              is_full;
   logic [TIME_W-1:0] runtime_ms;

   modport source (output valid, voltage_mv, charge_percent, is_charging, is_full,
                   runtime_ms, input ready);
   modport sink (input valid, voltage_mv, charge_percent, is_charging, is_full,
                 runtime_ms, output ready);
endinterface

// Result channel: the statistics after each sample.
interface bds_rsp_if;
   import bds_pkg::*;

   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  charge_sessions;
   logic [CNT_W-1:0]  charged_tenths;
   logic [CNT_W-1:0]  full_events;
   logic [CNT_W-1:0]  sample_count;
   logic [NORM_W-1:0] latest_norm_ms;
   logic [NORM_W-1:0] reference_norm_ms;
   logic [VOLT_W-1:0] min_mv;
   logic [VOLT_W-1:0] max_mv;
   logic              save_request;
   logic              tracking_active;

   modport source (output valid, charge_sessions, charged_tenths, full_events,
                   sample_count, latest_norm_ms, reference_norm_ms, min_mv, max_mv,
                   save_request, tracking_active, input ready);
   modport sink (input valid, charge_sessions, charged_tenths, full_events,
                 sample_count, latest_norm_ms, reference_norm_ms, min_mv, max_mv,
                 save_request, tracking_active, output ready);
endinterface

// ----- rtl/battery_discharge_statistics_core.sv -----
// Battery discharge statistics core.
// Each item on req_ch is one battery sample (voltage, percent, charger flags,
// accumulated runtime). Each accepted item yields exactly one item on rsp_ch
// carrying the counters, voltage extremes and normalized run times after it.
// Both channels use valid/ready; an item moves when both are high.
// A sample that completes a counted discharge run goes through an update step,
// a scaling multiply, a 47-step restoring divider that yields one quotient bit
// per cycle, a step to take the quotient and the load of the output register,
// after which rsp_ch.valid rises. Any other sample goes through the update and
// the load only. req_ch.ready is high only while no sample is in work, so a new
// item is taken only after the last one has been loaded into the output register.
// The result sits in an output register; a new sample is accepted while it
// waits, and that sample's result is held back until rsp_ch takes the old one.
// The csr_ port writes one register per cycle at csr_we; write it only while
// the block is idle.
// Synchronous reset restores the register defaults and clears all statistics.
module battery_discharge_statistics_core (
   input  logic                           clock,
   input  logic                           reset,
   bds_req_if.sink                        req_ch,
   bds_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [bds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bds_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bds_pkg::*;

   `include "battery_discharge_statistics_core_macros.svh"

   cfg_type       cfg;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Pack the incoming sample.
   assign req_item.voltage_mv     = req_ch.voltage_mv;
   assign req_item.charge_percent = req_ch.charge_percent;
   assign req_item.is_charging    = req_ch.is_charging;
   assign req_item.is_full        = req_ch.is_full;
   assign req_item.runtime_ms     = req_ch.runtime_ms;

   bds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bds_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // Unpack the result item.
   assign rsp_ch.charge_sessions   = rsp_item.charge_sessions;
   assign rsp_ch.charged_tenths    = rsp_item.charged_tenths;
   assign rsp_ch.full_events       = rsp_item.full_events;
   assign rsp_ch.sample_count      = rsp_item.sample_count;
   assign rsp_ch.latest_norm_ms    = rsp_item.latest_norm_ms;
   assign rsp_ch.reference_norm_ms = rsp_item.reference_norm_ms;
   assign rsp_ch.min_mv            = rsp_item.min_mv;
   assign rsp_ch.max_mv            = rsp_item.max_mv;
   assign rsp_ch.save_request      = rsp_item.save_request;
   assign rsp_ch.tracking_active   = rsp_item.tracking_active;

   // Only one sample is in work at a time.
   `BDS_ASSERT_NEXT(a_one_in_work, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "sample accepted while another is in work")

   // A completed run always ends tracking.
   `BDS_ASSERT_NOW(a_save_ends_run, clock, reset, rsp_ch.valid && rsp_ch.save_request, !rsp_ch.tracking_active, "save request with tracking still active")

   // The reference never falls below the latest normalized value.
   `BDS_ASSERT_NOW(a_reference_max, clock, reset, rsp_ch.valid, rsp_ch.reference_norm_ms >= rsp_ch.latest_norm_ms, "reference below latest normalized run time")

endmodule

// ----- rtl/bds_csr.sv -----
module bds_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bds_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bds_pkg::cfg_type                cfg
);
   import bds_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; other indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VALID_LOW:  cfg_in.valid_low_mv  = csr_wdata[VOLT_W-1:0];
            CSR_VALID_HIGH: cfg_in.valid_high_mv = csr_wdata[VOLT_W-1:0];
            CSR_START_PCT:  cfg_in.start_percent = csr_wdata[PCT_W-1:0];
            CSR_END_PCT:    cfg_in.end_percent   = csr_wdata[PCT_W-1:0];
            CSR_MIN_USED:   cfg_in.min_consumed  = csr_wdata[PCT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valid_low_mv  <= VALID_LOW_RESET;
         cfg_ff.valid_high_mv <= VALID_HIGH_RESET;
         cfg_ff.start_percent <= START_PCT_RESET;
         cfg_ff.end_percent   <= END_PCT_RESET;
         cfg_ff.min_consumed  <= MIN_USED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bds_ctrl.sv -----
module bds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bds_pkg::dp_status_type status,
   output bds_pkg::dp_cmd_type    cmd
);
   import bds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   state_type         state_ff;
   state_type         state_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              out_free;

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.need_div ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bds_dp.sv -----
module bds_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  bds_pkg::cfg_type        cfg,
   input  bds_pkg::req_item_type   req_item,
   input  bds_pkg::dp_cmd_type     cmd,
   output bds_pkg::dp_status_type  status,
   output bds_pkg::rsp_item_type   rsp_item
);
   import bds_pkg::*;

   // Captured sample and result register.
   req_item_type in_ff;
   rsp_item_type rsp_ff;

   // Statistics state.
   logic              prev_chg_ff;
   logic              prev_full_ff;
   logic [PCT_W-1:0]  prev_pct_ff;
   logic              tracking_ff;
   logic [PCT_W-1:0]  start_pct_ff;
   logic [TIME_W-1:0] start_time_ff;
   logic [VOLT_W-1:0] volt_min_ff;
   logic [VOLT_W-1:0] volt_max_ff;
   logic [CNT_W-1:0]  sessions_ff;
   logic [CNT_W-1:0]  tenths_ff;
   logic [CNT_W-1:0]  full_cnt_ff;
   logic [CNT_W-1:0]  samples_ff;
   logic [NORM_W-1:0] latest_ff;
   logic [NORM_W-1:0] reference_ff;
   logic              save_ff;

   // Division operands and working registers.
   logic [TIME_W-1:0] elapsed_ff;
   logic [PCT_W-1:0]  used_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [PCT_W-1:0]  rem_ff;

   // Update logic signals.
   logic              volt_ok;
   logic              chg_rise;
   logic              full_rise;
   logic [PCT_W-1:0]  prev_eff;
   logic              add_tenths;
   logic [PCT_W-1:0]  pct_delta;
   logic              trk_a;
   logic [PCT_W-1:0]  spct_a;
   logic [TIME_W-1:0] stime_a;
   logic              begin_run;
   logic              trk_b;
   logic [PCT_W-1:0]  spct_b;
   logic [TIME_W-1:0] stime_b;
   logic              end_run;
   logic [PCT_W-1:0]  used;
   logic [PCT_W:0]    trial;
   logic              trial_ge;
   logic [NORM_W-1:0] norm;

   // Voltage window, edges and the charging accumulation.
   assign volt_ok    = (in_ff.voltage_mv >= cfg.valid_low_mv) &&
                       (in_ff.voltage_mv <= cfg.valid_high_mv);
   assign chg_rise   = in_ff.is_charging && !prev_chg_ff;
   assign full_rise  = in_ff.is_full && !prev_full_ff;
   assign prev_eff   = chg_rise ? in_ff.charge_percent : prev_pct_ff;
   assign add_tenths = in_ff.is_charging && (in_ff.charge_percent > prev_eff);
   assign pct_delta  = in_ff.charge_percent - prev_eff;

   // Run tracking: a full-charge edge restarts at 100 percent, then the
   // start threshold on battery, then the end threshold.
   assign trk_a   = full_rise ? 1'b1 : tracking_ff;
   assign spct_a  = full_rise ? FULL_PERCENT : start_pct_ff;
   assign stime_a = full_rise ? in_ff.runtime_ms : start_time_ff;

   assign begin_run = !in_ff.is_charging && !in_ff.is_full && !trk_a &&
                      (in_ff.charge_percent >= cfg.start_percent);
   assign trk_b   = begin_run ? 1'b1 : trk_a;
   assign spct_b  = begin_run ? in_ff.charge_percent : spct_a;
   assign stime_b = begin_run ? in_ff.runtime_ms : stime_a;

   assign end_run = !in_ff.is_charging && !in_ff.is_full && trk_b &&
                    (in_ff.charge_percent <= cfg.end_percent);
   assign used    = (spct_b > in_ff.charge_percent) ? (spct_b - in_ff.charge_percent)
                                                    : '0;

   assign status.need_div = end_run && (used != '0) && (used >= cfg.min_consumed);

   // One restoring division step: shift in the next dividend bit.
   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, used_ff});

   // Saturate the quotient to the result range.
   assign norm = (quo_ff[PROD_W-1:NORM_W] != '0) ? '1 : quo_ff[NORM_W-1:0];

   // Sample capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_item;
      end
   end

   // Statistics state.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_chg_ff   <= 1'b0;
         prev_full_ff  <= 1'b0;
         prev_pct_ff   <= '0;
         tracking_ff   <= 1'b0;
         start_pct_ff  <= '0;
         start_time_ff <= '0;
         volt_min_ff   <= VOLT_MIN_RESET;
         volt_max_ff   <= '0;
         sessions_ff   <= '0;
         tenths_ff     <= '0;
         full_cnt_ff   <= '0;
         samples_ff    <= '0;
         latest_ff     <= '0;
         reference_ff  <= '0;
         save_ff       <= 1'b0;
      end else if (cmd.update) begin
         if (volt_ok && (in_ff.voltage_mv < volt_min_ff)) begin
            volt_min_ff <= in_ff.voltage_mv;
         end
         if (volt_ok && (in_ff.voltage_mv > volt_max_ff)) begin
            volt_max_ff <= in_ff.voltage_mv;
         end
         if (chg_rise) begin
            sessions_ff <= sessions_ff + 1'b1;
         end
         if (add_tenths) begin
            tenths_ff <= tenths_ff + CNT_W'(pct_delta) * TENTHS_PER_PCT;
         end
         if (full_rise) begin
            full_cnt_ff <= full_cnt_ff + 1'b1;
         end
         tracking_ff   <= trk_b && !end_run;
         start_pct_ff  <= spct_b;
         start_time_ff <= stime_b;
         prev_chg_ff   <= in_ff.is_charging;
         prev_full_ff  <= in_ff.is_full;
         prev_pct_ff   <= in_ff.charge_percent;
         save_ff       <= 1'b0;
      end else if (cmd.finish) begin
         latest_ff <= norm;
         if (norm > reference_ff) begin
            reference_ff <= norm;
         end
         samples_ff <= samples_ff + 1'b1;
         save_ff    <= 1'b1;
      end
   end

   // Division operands, scaling and the restoring divider.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         elapsed_ff <= in_ff.runtime_ms - stime_b;
         used_ff    <= used;
      end
      if (cmd.mul) begin
         quo_ff <= PROD_W'(elapsed_ff) * PROD_W'(NORM_SCALE);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[PROD_W-2:0], trial_ge};
         rem_ff <= trial_ge ? PCT_W'(trial - {1'b0, used_ff}) : trial[PCT_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.charge_sessions   <= sessions_ff;
         rsp_ff.charged_tenths    <= tenths_ff;
         rsp_ff.full_events       <= full_cnt_ff;
         rsp_ff.sample_count      <= samples_ff;
         rsp_ff.latest_norm_ms    <= latest_ff;
         rsp_ff.reference_norm_ms <= reference_ff;
         rsp_ff.min_mv            <= volt_min_ff;
         rsp_ff.max_mv            <= volt_max_ff;
         rsp_ff.save_request      <= save_ff;
         rsp_ff.tracking_active   <= tracking_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule
